/* hw/rtl/sfpu_pkg.sv */
// Shared types and constants for the scan frame pixel unpacker.
// Used by the front end, the job queue, the pixel back end and the top level.
`default_nettype none

package sfpu_pkg;

  // Column arithmetic width. It covers lines of up to 1023 segments, including
  // the negative sync skew and the signed channel offsets.
  localparam int COL_W = 16;

  localparam int WORDS         = 15;
  localparam int FINE_W        = 6;
  localparam int PIX_PER_FRAME = 15;
  localparam int SMOOTH_RUN    = 5;
  localparam int SMOOTH_COUNT  = 3;
  localparam int ALARM_WORDS   = 12;
  localparam int SYNC_THRESHOLD = 70;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] ALARM_ODD  = 8'hFB;
  localparam logic [7:0] ALARM_EVEN = 8'h07;

  // Division by ten of an 8-bit code as a multiply by a reciprocal.
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_TAG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VIS_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_OFFSET  = 2'd2;

  // Tag mode codes. The unused code behaves like a forced true tag.
  localparam logic [1:0] TAG_FRAME = 2'd0;
  localparam logic [1:0] TAG_FALSE = 2'd1;
  localparam logic [1:0] TAG_TRUE  = 2'd2;

  typedef struct packed {
    logic [15:0]                          line_index;
    logic                                 reverse;
    logic                                 tag;
    logic signed [COL_W-1:0]              base;
    logic [WORDS-1:0][FINE_W-1:0]         fine;
    logic [SMOOTH_COUNT-1:0][7:0]         smooth;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/sfpu_front.sv */
// Front end: accepts frames, detects line syncs and keeps the line state.
// Data frames before the end of the line become pixel jobs pushed into the queue. Depends on sfpu_pkg.
`default_nettype none

module sfpu_front import sfpu_pkg::*; #(
  parameter int SEGMENTS_PER_LINE = 490
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frame_valid,
  output logic             frame_stall,
  input  wire logic [63:0] words_lo,
  input  wire logic [55:0] words_hi,
  input  wire logic        frame_tag,
  input  wire logic [1:0]  tag_mode,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  localparam int SEG_W = $clog2(SEGMENTS_PER_LINE + 1);

  logic [WORDS:1][7:0] wd;
  logic [3:0]          wmatch [ALARM_WORDS];
  logic [4:0]          pair   [ALARM_WORDS/2];
  logic [5:0]          quad   [ALARM_WORDS/4];
  logic [6:0]          match;
  logic                accept;
  logic                is_sync;
  logic                is_blank;
  logic                at_end;
  logic                tag;
  logic [7:0]          code;
  logic [15:0]         skew_prod;
  logic signed [COL_W-1:0] pos_ext;
  logic signed [COL_W-1:0] skew_ext;

  logic             scan_reverse;
  logic [4:0]       sync_skew;
  logic [SEG_W-1:0] seg_pos;
  logic [15:0]      line_count;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

  assign wd = {words_hi, words_lo};

  always_comb begin
    for (int k = 0; k < ALARM_WORDS; k++) begin
      // Word k+1: odd words against 0xFB, even words against 0x07.
      wmatch[k] = ones8(~(wd[k+1] ^ ((k % 2 == 0) ? ALARM_ODD : ALARM_EVEN)));
    end
    for (int j = 0; j < ALARM_WORDS/2; j++) begin
      pair[j] = 5'(wmatch[2*j]) + 5'(wmatch[2*j+1]);
    end
    for (int j = 0; j < ALARM_WORDS/4; j++) begin
      quad[j] = 6'(pair[2*j]) + 6'(pair[2*j+1]);
    end
    match = 7'(quad[0]) + 7'(quad[1]) + 7'(quad[2]);
  end

  assign is_sync  = match > 7'(SYNC_THRESHOLD);
  assign is_blank = (wd[1] == 8'd0) && (wd[2] == 8'd0);
  assign at_end   = seg_pos >= SEG_W'(SEGMENTS_PER_LINE);

  assign frame_stall = q_full;
  assign accept      = frame_valid && !q_full;
  assign q_push      = accept && !is_sync && !is_blank && !at_end;

  assign code      = {wd[13][7:2], wd[14][7:6]};
  assign skew_prod = code * DIV10_MUL;

  always_comb begin
    case (tag_mode)
      TAG_FRAME: tag = frame_tag;
      TAG_FALSE: tag = 1'b0;
      default:   tag = 1'b1;
    endcase
  end

  assign pos_ext  = signed'(COL_W'(seg_pos));
  assign skew_ext = signed'(COL_W'(sync_skew));

  always_comb begin
    q_job.line_index = line_count;
    q_job.reverse    = scan_reverse;
    q_job.tag        = tag;
    q_job.base       = (pos_ext <<< 4) - pos_ext - skew_ext;
    for (int k = 0; k < WORDS; k++) begin
      q_job.fine[k] = wd[k+1][7:2];
    end
    q_job.smooth[0] = {wd[1][1:0], wd[2][1:0], wd[3][1:0], wd[4][1:0]};
    q_job.smooth[1] = {wd[6][1:0], wd[7][1:0], wd[8][1:0], wd[9][1:0]};
    q_job.smooth[2] = {wd[11][1:0], wd[12][1:0], wd[13][1:0], wd[14][1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_reverse <= 1'b0;
      sync_skew    <= '0;
      seg_pos      <= '0;
      line_count   <= '0;
    end else if (accept) begin
      if (is_sync) begin
        scan_reverse <= wd[15][2];
        sync_skew    <= skew_prod[DIV10_SHIFT +: 5];
        seg_pos      <= '0;
        line_count   <= line_count + 16'd1;
      end else if (!is_blank) begin
        if (at_end) begin
          seg_pos <= SEG_W'(SEGMENTS_PER_LINE);
        end else begin
          seg_pos <= seg_pos + SEG_W'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    seg_pos <= SEG_W'(SEGMENTS_PER_LINE))
    else $error("segment position ran past the end of the line");

endmodule

`default_nettype wire

/* hw/rtl/sfpu_queue.sv */
// Short job queue between the front end and the pixel back end.
// Holds QUEUE_DEPTH jobs of type job_t from sfpu_pkg.
`default_nettype none

module sfpu_queue import sfpu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      job_in,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      job_out
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign job_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

/* hw/rtl/sfpu_back.sv */
// Pixel back end: walks the head job over fifteen pixel writes, one per unstalled
// cycle. Computes mirrored, offset-adjusted columns and write flags. Depends on sfpu_pkg.
`default_nettype none

module sfpu_back import sfpu_pkg::*; #(
  parameter int SEGMENTS_PER_LINE = 490
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic signed [9:0] vis_offset,
  input  wire logic signed [9:0] ir_offset,
  input  wire logic              q_empty,
  input  job_t                   job,
  output logic                   q_pop,
  output logic                   pixel_valid,
  input  wire logic              pixel_stall,
  output logic [15:0]            line_index,
  output logic [12:0]            vis_column,
  output logic                   vis_write,
  output logic [7:0]             vis_value,
  output logic [12:0]            ir_column,
  output logic                   ir_write,
  output logic [7:0]             ir_value,
  output logic                   last_pixel
);

  localparam int LINEW = SEGMENTS_PER_LINE * PIX_PER_FRAME;
  localparam logic signed [COL_W-1:0] LINEW_S = COL_W'(LINEW);

  logic [3:0]              cnt;
  logic [3:0]              pidx;
  logic [1:0]              sidx;
  logic                    advance;
  logic                    last;
  logic [7:0]              fine_px;
  logic [7:0]              smooth_px;
  logic signed [COL_W-1:0] i_ext;
  logic signed [COL_W-1:0] cv;
  logic signed [COL_W-1:0] ci;
  logic signed [COL_W-1:0] cv_out;
  logic signed [COL_W-1:0] ci_out;
  logic                    wv;
  logic                    wi;

  assign advance = !pixel_valid || !pixel_stall;
  assign last    = cnt == 4'(PIX_PER_FRAME - 1);
  assign q_pop   = advance && !q_empty && last;

  always_comb begin
    pidx = job.reverse ? 4'(PIX_PER_FRAME - 1) - cnt : cnt;
    if (pidx < 4'(SMOOTH_RUN)) begin
      sidx = 2'd0;
    end else if (pidx < 4'(2 * SMOOTH_RUN)) begin
      sidx = 2'd1;
    end else begin
      sidx = 2'd2;
    end
    fine_px   = {job.fine[pidx], 2'b00};
    smooth_px = job.smooth[sidx];

    i_ext = signed'(COL_W'(cnt));
    if (job.reverse) begin
      cv = job.base - i_ext + COL_W'(vis_offset);
      ci = job.base - i_ext + COL_W'(ir_offset);
    end else begin
      cv = job.base + i_ext;
      ci = job.base + i_ext;
    end
    wv = (cv > 0) && (cv < LINEW_S);
    wi = (ci > 0) && (ci < LINEW_S);
    // Reverse scans fill the line from its far end.
    cv_out = job.reverse ? (LINEW_S - COL_W'(1)) - cv : cv;
    ci_out = job.reverse ? (LINEW_S - COL_W'(1)) - ci : ci;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      cnt         <= '0;
    end else if (advance) begin
      pixel_valid <= !q_empty;
      if (!q_empty) begin
        cnt <= last ? '0 : cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      line_index <= job.line_index;
      vis_column <= wv ? cv_out[12:0] : '0;
      vis_write  <= wv;
      vis_value  <= job.tag ? smooth_px : fine_px;
      ir_column  <= wi ? ci_out[12:0] : '0;
      ir_write   <= wi;
      ir_value   <= job.tag ? fine_px : smooth_px;
      last_pixel <= last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !vis_write |-> vis_column == 13'd0)
    else $error("unwritten visible pixel carries a column");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> cnt == 4'd0)
    else $error("pixel counter not rewound after the last write of a frame");

endmodule

`default_nettype wire

/* hw/rtl/scan_frame_pixel_unpacker.sv */
// Scan frame pixel unpacker. A frame is accepted in any cycle in which the job
// queue (two entries) has room; sync frames, blank frames and frames past the
// end of the line give no pixel writes. A data frame gives fifteen pixel writes,
// one per cycle unless the pixel output stalls, paced by the back end's pixel
// counter. An output register parts the pixel channel from the queue, and a new
// frame is taken while earlier pixels are still being delivered. Configuration
// is written through the cfg port, which is always ready.
`default_nettype none

module scan_frame_pixel_unpacker import sfpu_pkg::*; #(
  parameter int SEGMENTS_PER_LINE = 490
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   frame_valid,
  output logic                        frame_stall,
  input  wire logic [63:0]            words_lo,
  input  wire logic [55:0]            words_hi,
  input  wire logic                   frame_tag,
  output logic                        pixel_valid,
  input  wire logic                   pixel_stall,
  output logic [15:0]                 line_index,
  output logic [12:0]                 vis_column,
  output logic                        vis_write,
  output logic [7:0]                  vis_value,
  output logic [12:0]                 ir_column,
  output logic                        ir_write,
  output logic [7:0]                  ir_value,
  output logic                        last_pixel
);

  logic              [1:0] tag_mode;
  logic signed       [9:0] vis_offset;
  logic signed       [9:0] ir_offset;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  job_t                    job_in;
  job_t                    job_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mode   <= TAG_FRAME;
      vis_offset <= '0;
      ir_offset  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TAG_MODE:   tag_mode   <= cfg_data[1:0];
        REG_VIS_OFFSET: vis_offset <= signed'(cfg_data);
        REG_IR_OFFSET:  ir_offset  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  sfpu_front #(
    .SEGMENTS_PER_LINE(SEGMENTS_PER_LINE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .words_lo   (words_lo),
    .words_hi   (words_hi),
    .frame_tag  (frame_tag),
    .tag_mode   (tag_mode),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (job_in)
  );

  sfpu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .job_in (job_in),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .job_out(job_head)
  );

  sfpu_back #(
    .SEGMENTS_PER_LINE(SEGMENTS_PER_LINE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .vis_offset (vis_offset),
    .ir_offset  (ir_offset),
    .q_empty    (q_empty),
    .job        (job_head),
    .q_pop      (q_pop),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .line_index (line_index),
    .vis_column (vis_column),
    .vis_write  (vis_write),
    .vis_value  (vis_value),
    .ir_column  (ir_column),
    .ir_write   (ir_write),
    .ir_value   (ir_value),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for scan_frame_pixel_unpacker: it drives scanner frames and register
// writes, predicts every pixel write in-line and compares the results field by field.
// Depends on sfpu_pkg for the register indexes, tag mode codes and alarm constants.
`default_nettype none

module tb_top import sfpu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENTS     = 490;
  localparam int LINE_W       = SEGMENTS * PIX_PER_FRAME;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 90;
  localparam int MAX_PRINTED  = 100;
  localparam int TIMEOUT_NS   = 4_000_000;

  localparam logic [1:0]  TAG_SPARE = 2'd3;
  localparam logic [7:0]  FINE_MASK = 8'hFC;

  typedef struct {
    logic [15:0] line_index;
    logic [12:0] vis_column;
    logic        vis_write;
    logic [7:0]  vis_value;
    logic [12:0] ir_column;
    logic        ir_write;
    logic [7:0]  ir_value;
    logic        last_pixel;
  } pixel_write_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   frame_valid;
  logic                   frame_stall;
  logic [63:0]            words_lo;
  logic [55:0]            words_hi;
  logic                   frame_tag;
  logic                   pixel_valid;
  logic                   pixel_stall;
  logic [15:0]            line_index;
  logic [12:0]            vis_column;
  logic                   vis_write;
  logic [7:0]             vis_value;
  logic [12:0]            ir_column;
  logic                   ir_write;
  logic [7:0]             ir_value;
  logic                   last_pixel;

  // Predicted block state and register copies.
  logic        scan_back   = 1'b0;
  logic [7:0]  sync_word   = '0;
  int          seg_index   = 0;
  logic [15:0] line_number = '0;
  logic [1:0]  tag_sel     = TAG_FRAME;
  int          vis_shift   = 0;
  int          ir_shift    = 0;

  pixel_write_t pixel_queue[$];
  pixel_write_t want_px;
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;
  bit           stall_on;
  int           stall_left = 0;
  int           hold_requests;
  int           holds_served = 0;

  scan_frame_pixel_unpacker #(.SEGMENTS_PER_LINE(SEGMENTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .words_lo(words_lo), .words_hi(words_hi), .frame_tag(frame_tag),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .line_index(line_index), .vis_column(vis_column), .vis_write(vis_write),
    .vis_value(vis_value), .ir_column(ir_column), .ir_write(ir_write),
    .ir_value(ir_value), .last_pixel(last_pixel)
  );

  always #2 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] rand_lo();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [55:0] rand_hi();
    return 56'({$urandom, $urandom});
  endfunction

  // Words 1 to 12 of the alarm pattern with the given number of distinct bits flipped.
  function automatic logic [95:0] alarm_bits(int flips);
    logic [95:0] pattern;
    logic [95:0] flip_mask;
    for (int k = 0; k < ALARM_WORDS; k++)
      pattern[8*k +: 8] = (k % 2 == 0) ? ALARM_ODD : ALARM_EVEN;
    flip_mask = '0;
    while ($countones(flip_mask) < flips)
      flip_mask[$urandom_range(95, 0)] = 1'b1;
    return pattern ^ flip_mask;
  endfunction

  // Updates the predicted state for one accepted frame and queues its pixel writes.
  function automatic void predict_frame(logic [63:0] lo, logic [55:0] hi, logic tag_bit);
    logic [7:0]   w [1:WORDS];
    logic [7:0]   smooth [0:SMOOTH_COUNT-1];
    logic [7:0]   fine_px;
    logic [7:0]   smooth_px;
    logic         tag;
    int           hits;
    int           base;
    int           cv;
    int           ci;
    int           p;
    pixel_write_t px;
    for (int k = 1; k <= 8; k++) w[k] = lo[8*(k-1) +: 8];
    for (int k = 9; k <= WORDS; k++) w[k] = hi[8*(k-9) +: 8];
    hits = 0;
    for (int k = 1; k <= ALARM_WORDS; k++)
      hits += 8 - $countones(w[k] ^ ((k % 2 == 1) ? ALARM_ODD : ALARM_EVEN));
    if (hits > SYNC_THRESHOLD) begin
      scan_back = w[15][2];
      sync_word = {w[13][7:2], w[14][7:6]};
      seg_index = 0;
      line_number++;
      return;
    end
    if (w[1] == '0 && w[2] == '0) return;
    if (seg_index >= SEGMENTS) return;

    case (tag_sel)
      TAG_FRAME: tag = tag_bit;
      TAG_FALSE: tag = 1'b0;
      default:   tag = 1'b1;
    endcase
    smooth[0] = {w[1][1:0], w[2][1:0], w[3][1:0], w[4][1:0]};
    smooth[1] = {w[6][1:0], w[7][1:0], w[8][1:0], w[9][1:0]};
    smooth[2] = {w[11][1:0], w[12][1:0], w[13][1:0], w[14][1:0]};
    base = seg_index * PIX_PER_FRAME - int'(sync_word / 10);

    for (int i = 0; i < PIX_PER_FRAME; i++) begin
      p = scan_back ? PIX_PER_FRAME - 1 - i : i;
      fine_px   = w[1 + p] & FINE_MASK;
      smooth_px = smooth[p / SMOOTH_RUN];
      if (scan_back) begin
        cv = base - i + vis_shift;
        ci = base - i + ir_shift;
      end else begin
        cv = base + i;
        ci = base + i;
      end
      px.vis_write = (cv > 0 && cv < LINE_W);
      px.ir_write  = (ci > 0 && ci < LINE_W);
      // Reverse scan mirrors the column within the line.
      if (scan_back) begin
        cv = LINE_W - 1 - cv;
        ci = LINE_W - 1 - ci;
      end
      px.line_index = line_number;
      px.vis_column = px.vis_write ? cv[12:0] : '0;
      px.ir_column  = px.ir_write ? ci[12:0] : '0;
      px.vis_value  = tag ? smooth_px : fine_px;
      px.ir_value   = tag ? fine_px : smooth_px;
      px.last_pixel = (i == PIX_PER_FRAME - 1);
      pixel_queue.push_back(px);
    end
    seg_index++;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Pixel receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      stall_left = HOLD_CYCLES;
      pixel_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      pixel_stall <= 1'b1;
    end else begin
      pixel_stall <= 1'b0;
      if (stall_on) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("pixel write with none outstanding");
      end else begin
        want_px = pixel_queue.pop_front();
        check_field("line_index", line_index, want_px.line_index);
        check_field("vis_column", vis_column, want_px.vis_column);
        check_field("vis_write", vis_write, want_px.vis_write);
        check_field("vis_value", vis_value, want_px.vis_value);
        check_field("ir_column", ir_column, want_px.ir_column);
        check_field("ir_write", ir_write, want_px.ir_write);
        check_field("ir_value", ir_value, want_px.ir_value);
        check_field("last_pixel", last_pixel, want_px.last_pixel);
      end
    end
  end

  task automatic send_frame(logic [63:0] lo, logic [55:0] hi, logic tag);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    words_lo    <= lo;
    words_hi    <= hi;
    frame_tag   <= tag;
    do @(posedge clk); while (frame_stall);
    predict_frame(lo, hi, tag);
  endtask

  task automatic send_sync(logic rev, logic [7:0] code, int flips);
    logic [95:0] alarm;
    logic [7:0]  w13;
    logic [7:0]  w14;
    logic [7:0]  w15;
    alarm = alarm_bits(flips);
    w13 = {code[7:2], 2'($urandom)};
    w14 = {code[1:0], 6'($urandom)};
    w15 = 8'($urandom);
    w15[2] = rev;
    send_frame(alarm[63:0], {w15, w14, w13, alarm[95:64]}, 1'($urandom));
  endtask

  task automatic send_random_data();
    send_frame(rand_lo(), rand_hi(), 1'($urandom));
  endtask

  // Waits until every pixel write has arrived and frames without results have drained.
  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [1:0] mode, int vis, int ir);
    logic [CFG_INDEX_W-1:0] widx [3];
    logic [CFG_DATA_W-1:0]  wdata [3];
    wait_idle();
    widx = '{REG_TAG_MODE, REG_VIS_OFFSET, REG_IR_OFFSET};
    wdata[0] = CFG_DATA_W'($urandom);
    wdata[0][1:0] = mode;
    wdata[1] = vis[CFG_DATA_W-1:0];
    wdata[2] = ir[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      cfg_index <= widx[r];
      cfg_data  <= wdata[r];
      do @(posedge clk); while (!cfg_ready);
      case (widx[r])
        REG_TAG_MODE:   tag_sel = wdata[r][1:0];
        REG_VIS_OFFSET: vis_shift = $signed(wdata[r]);
        REG_IR_OFFSET:  ir_shift = $signed(wdata[r]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_offset();
    case ($urandom_range(3, 0))
      0:       return -512;
      1:       return 511;
      default: return int'($urandom_range(1023, 0)) - 512;
    endcase
  endfunction

  // First frame after reset: forward scan from column zero, so pixel 0 is not written.
  task automatic test_reset_state();
    send_frame('1, '1, 1'b1);
  endtask

  task automatic test_blank_frames();
    logic [63:0] lo;
    send_frame('0, '0, 1'b0);
    lo = rand_lo();
    lo[15:0] = '0;
    send_frame(lo, rand_hi(), 1'b1);
    lo[15:8] = 8'h01;
    send_frame(lo, rand_hi(), 1'b0);
    lo[15:0] = 16'h0080;
    send_frame(lo, rand_hi(), 1'b1);
  endtask

  task automatic test_sync_threshold();
    logic [95:0] alarm;
    logic [55:0] hi;
    send_sync(1'b0, 8'hFF, 25);
    send_random_data();
    alarm = alarm_bits(26);
    hi = rand_hi();
    send_frame(alarm[63:0], {hi[55:32], alarm[95:64]}, 1'b0);
    send_sync(1'b0, 8'h00, 0);
    send_random_data();
  endtask

  task automatic test_tag_modes();
    logic [1:0] modes [4];
    modes = '{TAG_FRAME, TAG_FALSE, TAG_TRUE, TAG_SPARE};
    foreach (modes[m]) begin
      set_registers(modes[m], 0, 0);
      send_frame(rand_lo(), rand_hi(), 1'b0);
      send_frame(rand_lo(), rand_hi(), 1'b1);
    end
  endtask

  task automatic test_reverse_scan();
    set_registers(TAG_FRAME, -512, 511);
    send_sync(1'b1, 8'hFF, 0);
    send_random_data();
    send_random_data();
    set_registers(TAG_TRUE, 511, -512);
    send_random_data();
  endtask

  // The receiver holds off while frames keep coming, so the block must stall its input.
  task automatic test_receiver_holdoff();
    send_sync(1'b0, 8'($urandom), 0);
    wait_idle();
    hold_requests <= hold_requests + 1;
    gaps_on = 1'b0;
    repeat (8) send_random_data();
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int          sent;
    logic [63:0] lo;
    logic [55:0] hi;
    logic [95:0] alarm;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3, 0) == 0)
        set_registers(2'($urandom), rand_offset(), rand_offset());
      gaps_on = ($urandom_range(4, 0) != 0);
      stall_on <= ($urandom_range(4, 0) != 0);
      if ($urandom_range(9, 0) < 8) begin
        // A line sync followed by a short run of data frames.
        send_sync(1'($urandom), 8'($urandom), $urandom_range(25, 0));
        sent++;
        repeat ($urandom_range(8, 1)) begin
          send_random_data();
          sent++;
        end
      end else begin
        case ($urandom_range(2, 0))
          0: begin
            lo = rand_lo();
            lo[15:0] = '0;
            send_frame(lo, rand_hi(), 1'($urandom));
          end
          1: begin
            alarm = alarm_bits($urandom_range(40, 26));
            hi = rand_hi();
            send_frame(alarm[63:0], {hi[55:32], alarm[95:64]}, 1'($urandom));
            sent++;
          end
          default: begin
            send_random_data();
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    frame_valid   <= 1'b0;
    words_lo      <= '0;
    words_hi      <= '0;
    frame_tag     <= 1'b0;
    stall_on      <= 1'b1;
    hold_requests <= 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_blank_frames();
    test_sync_threshold();
    test_tag_modes();
    test_reverse_scan();
    test_receiver_holdoff();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
